FILE: hw/rtl/lcdns_pkg.sv
package lcdns_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // request codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_BYTE   = 3'd1;
    localparam logic [2:0] CMD_DATA   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_HOME   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_FUNCTION_SET    = 3'd0;
    localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd1;
    localparam logic [2:0] REG_ENTRY_MODE      = 3'd2;
    localparam logic [2:0] REG_CLEAR           = 3'd3;
    localparam logic [2:0] REG_HOME            = 3'd4;
    localparam logic [2:0] REG_ENABLE_HIGH     = 3'd5;
    localparam logic [2:0] REG_ENABLE_SETTLE   = 3'd6;

    localparam logic [7:0] RST_FUNCTION_SET    = 8'd40;
    localparam logic [7:0] RST_DISPLAY_CONTROL = 8'd14;
    localparam logic [7:0] RST_ENTRY_MODE      = 8'd6;
    localparam logic [7:0] RST_CLEAR           = 8'd1;
    localparam logic [7:0] RST_HOME            = 8'd2;
    localparam logic [9:0] RST_ENABLE_HIGH     = 10'd10;
    localparam logic [9:0] RST_ENABLE_SETTLE   = 10'd100;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;
    localparam logic [7:0] ROW1_BASE  = 8'h80;
    localparam logic [7:0] ROW2_BASE  = 8'hC0;

    localparam logic [3:0] RAW_WAKE = 4'h3;
    localparam logic [3:0] RAW_LAST = 4'h2;

    localparam logic [15:0] POWERUP_WAIT_US = 16'd40000;
    localparam logic [12:0] EXTRA_NONE_US   = 13'd0;
    localparam logic [12:0] EXTRA_WAKE1_US  = 13'd5000;
    localparam logic [12:0] EXTRA_WAKE2_US  = 13'd150;
    localparam logic [12:0] EXTRA_INITCMD_US = 13'd5000;
    localparam logic [12:0] EXTRA_INITCLR_US = 13'd7000;
    localparam logic [12:0] EXTRA_CLRHOME_US = 13'd2000;

    // init step numbering: raw nibbles 0..3, then byte pairs
    localparam logic [3:0] STEP_RAW_LAST  = 4'd3;
    localparam logic [3:0] STEP_INIT_LAST = 4'd11;
    localparam logic [3:0] STEP_BYTE_LAST = 4'd1;
    localparam logic [2:0] PAIR_FUNCTION  = 3'd2;
    localparam logic [2:0] PAIR_DISPLAY   = 3'd3;
    localparam logic [2:0] PAIR_CLEAR     = 3'd4;
    localparam logic [2:0] PAIR_ENTRY     = 3'd5;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_BYTE,
        JOB_CLEAR,
        JOB_HOME
    } job_kind_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic [1:0] row;
        logic [4:0] column;
    } req_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] wait_before_us;
        logic [9:0]  high_time_us;
        logic [12:0] wait_after_us;
        logic        last;
    } result_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic [7:0] function_set_word;
        logic [7:0] display_control_word;
        logic [7:0] entry_mode_word;
        logic [7:0] clear_word;
        logic [7:0] home_word;
        logic [9:0] enable_high_us;
        logic [9:0] enable_settle_us;
    } cfg_t;

endpackage

FILE: hw/rtl/char_lcd_nibble_sequencer_unit.sv
// character lcd nibble sequencer, 4-bit bus. a request is taken on start while busy is
// low and turns into a run of bus writes, each shown for one cycle on result with strobe
// high; the receiver cannot stall, so every write must be captured the cycle it appears.
// the back sequencer emits one write per clock: init gives twelve writes, command, data,
// cursor, clear and home give two, and cursor with a bad row or an unknown code gives
// none. a request is first written into the queue, and its first write then reaches
// result through the output register. a short queue holds requests ahead of the
// sequencer and busy rises while it is full. configuration writes land at once
// (cfg_ready stays high) and should only be made while no writes are pending.
module char_lcd_nibble_sequencer_unit #(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  lcdns_pkg::req_t    request,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    // bus writes
    output logic               strobe,
    output lcdns_pkg::result_t result
);

    lcdns_pkg::cfg_t cfg_reg, cfg_next;
    lcdns_pkg::job_t push_job, head_job;
    logic            push, pop, full, not_empty;
    logic            cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = full;

    // register file update, unknown index is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lcdns_pkg::REG_FUNCTION_SET:    cfg_next.function_set_word    = cfg_data[7:0];
                lcdns_pkg::REG_DISPLAY_CONTROL: cfg_next.display_control_word = cfg_data[7:0];
                lcdns_pkg::REG_ENTRY_MODE:      cfg_next.entry_mode_word      = cfg_data[7:0];
                lcdns_pkg::REG_CLEAR:           cfg_next.clear_word           = cfg_data[7:0];
                lcdns_pkg::REG_HOME:            cfg_next.home_word            = cfg_data[7:0];
                lcdns_pkg::REG_ENABLE_HIGH:     cfg_next.enable_high_us       = cfg_data;
                lcdns_pkg::REG_ENABLE_SETTLE:   cfg_next.enable_settle_us     = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set_word    <= lcdns_pkg::RST_FUNCTION_SET;
            cfg_reg.display_control_word <= lcdns_pkg::RST_DISPLAY_CONTROL;
            cfg_reg.entry_mode_word      <= lcdns_pkg::RST_ENTRY_MODE;
            cfg_reg.clear_word           <= lcdns_pkg::RST_CLEAR;
            cfg_reg.home_word            <= lcdns_pkg::RST_HOME;
            cfg_reg.enable_high_us       <= lcdns_pkg::RST_ENABLE_HIGH;
            cfg_reg.enable_settle_us     <= lcdns_pkg::RST_ENABLE_SETTLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify the request, drop those that give no writes
    lcdns_front u_front (
        .start   (start),
        .full    (full),
        .request (request),
        .push    (push),
        .job     (push_job)
    );

    // queue between classification and sequencing
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    // back: one bus write per cycle from the head job
    lcdns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .job       (head_job),
        .cfg       (cfg_reg),
        .pop       (pop),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

FILE: hw/rtl/lcdns_front.sv
module lcdns_front (
    input  logic               start,
    input  logic               full,
    input  lcdns_pkg::req_t    request,
    output logic               push,
    output lcdns_pkg::job_t    job
);

    logic       job_valid;
    logic [7:0] offset;

    // cursor offset wraps modulo 256, column 0 gives all ones
    assign offset = {3'b000, request.column} - 8'd1;

    always_comb
    begin
        job_valid = 1'b1;
        job.kind  = lcdns_pkg::JOB_BYTE;
        job.rs    = 1'b0;
        job.data  = request.value;
        case (request.cmd)
            lcdns_pkg::CMD_INIT:
            begin
                job.kind = lcdns_pkg::JOB_INIT;
            end
            lcdns_pkg::CMD_BYTE:
            begin
                job.kind = lcdns_pkg::JOB_BYTE;
            end
            lcdns_pkg::CMD_DATA:
            begin
                job.rs = 1'b1;
            end
            lcdns_pkg::CMD_CURSOR:
            begin
                if (request.row == lcdns_pkg::ROW_FIRST)
                begin
                    job.data = offset | lcdns_pkg::ROW1_BASE;
                end
                else if (request.row == lcdns_pkg::ROW_SECOND)
                begin
                    job.data = offset | lcdns_pkg::ROW2_BASE;
                end
                else
                begin
                    job_valid = 1'b0;
                end
            end
            lcdns_pkg::CMD_CLEAR:
            begin
                job.kind = lcdns_pkg::JOB_CLEAR;
            end
            lcdns_pkg::CMD_HOME:
            begin
                job.kind = lcdns_pkg::JOB_HOME;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    assign push = start && !full && job_valid;

endmodule

FILE: hw/rtl/lcdns_queue.sv
module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcdns_pkg::job_t push_job,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output lcdns_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdns_pkg::job_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/lcdns_back.sv
module lcdns_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  lcdns_pkg::job_t    job,
    input  lcdns_pkg::cfg_t    cfg,
    output logic               pop,
    output logic               strobe,
    output lcdns_pkg::result_t result
);

    logic [3:0]  step_reg, step_next;
    logic        strobe_reg;
    lcdns_pkg::result_t result_reg, result_next;
    logic [7:0]  byte_sel;
    logic [12:0] extra;
    logic [3:0]  final_step;
    logic        is_init;
    logic        is_last;

    assign is_init = (job.kind == lcdns_pkg::JOB_INIT);

    always_comb
    begin
        byte_sel   = job.data;
        extra      = lcdns_pkg::EXTRA_NONE_US;
        final_step = lcdns_pkg::STEP_BYTE_LAST;
        case (job.kind)
            lcdns_pkg::JOB_INIT:
            begin
                final_step = lcdns_pkg::STEP_INIT_LAST;
                case (step_reg[3:1])
                    lcdns_pkg::PAIR_FUNCTION: byte_sel = cfg.function_set_word;
                    lcdns_pkg::PAIR_DISPLAY:  byte_sel = cfg.display_control_word;
                    lcdns_pkg::PAIR_CLEAR:    byte_sel = cfg.clear_word;
                    lcdns_pkg::PAIR_ENTRY:    byte_sel = cfg.entry_mode_word;
                    default:                  byte_sel = job.data;
                endcase
                if (step_reg == 4'd0)
                begin
                    extra = lcdns_pkg::EXTRA_WAKE1_US;
                end
                else if (step_reg == 4'd1)
                begin
                    extra = lcdns_pkg::EXTRA_WAKE2_US;
                end
                else if (step_reg > lcdns_pkg::STEP_RAW_LAST && step_reg[0])
                begin
                    extra = (step_reg[3:1] == lcdns_pkg::PAIR_CLEAR)
                          ? lcdns_pkg::EXTRA_INITCLR_US : lcdns_pkg::EXTRA_INITCMD_US;
                end
            end
            lcdns_pkg::JOB_CLEAR:
            begin
                byte_sel = cfg.clear_word;
                extra    = step_reg[0] ? lcdns_pkg::EXTRA_CLRHOME_US : lcdns_pkg::EXTRA_NONE_US;
            end
            lcdns_pkg::JOB_HOME:
            begin
                byte_sel = cfg.home_word;
                extra    = step_reg[0] ? lcdns_pkg::EXTRA_CLRHOME_US : lcdns_pkg::EXTRA_NONE_US;
            end
            default:
            begin
                byte_sel = job.data;
            end
        endcase
    end

    assign is_last = (step_reg == final_step);
    assign pop     = not_empty && is_last;

    always_comb
    begin
        result_next.rs = (job.kind == lcdns_pkg::JOB_BYTE) ? job.rs : 1'b0;
        if (is_init && step_reg <= lcdns_pkg::STEP_RAW_LAST)
        begin
            result_next.nibble = (step_reg == lcdns_pkg::STEP_RAW_LAST)
                               ? lcdns_pkg::RAW_LAST : lcdns_pkg::RAW_WAKE;
        end
        else
        begin
            // high nibble on even steps
            result_next.nibble = step_reg[0] ? byte_sel[3:0] : byte_sel[7:4];
        end
        result_next.wait_before_us = (is_init && step_reg == 4'd0)
                                   ? lcdns_pkg::POWERUP_WAIT_US : 16'd0;
        result_next.high_time_us   = cfg.enable_high_us;
        result_next.wait_after_us  = {3'b000, cfg.enable_settle_us} + extra;
        result_next.last           = is_last;
    end

    always_comb
    begin
        step_next = step_reg;
        if (not_empty)
        begin
            step_next = is_last ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 4'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            strobe_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
